// ===== rtl/rthp_pkg.sv =====
package rthp_pkg;

  localparam int unsigned NumKeys = 8;
  localparam logic [4:0] PosMax = 5'd31;

  localparam int unsigned KeyUdp = 0;
  localparam int unsigned KeyTcp = 1;
  localparam int unsigned KeyRaw = 2;
  localparam int unsigned KeyAvp = 3;
  localparam int unsigned KeySsrc = 4;
  localparam int unsigned KeySrv = 5;
  localparam int unsigned KeyCli = 6;
  localparam int unsigned KeyIlv = 7;

  localparam logic [1:0] KindRtpUdp = 2'd0;
  localparam logic [1:0] KindRtpTcp = 2'd1;
  localparam logic [1:0] KindRawUdp = 2'd2;

  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChDash = 8'h2d;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] cli_rtp;
    logic [15:0] cli_rtcp;
    logic [15:0] srv_rtp;
    logic [15:0] srv_rtcp;
    logic [15:0] data_ch;
    logic [15:0] ctrl_ch;
    logic [31:0] ssrc;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic [3:0] key_len(input logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd3: r = 4'd7;
      3'd4: r = 4'd5;
      3'd5, 3'd6, 3'd7: r = 4'd12;
      default: r = 4'd11;
    endcase
    return r;
  endfunction

  function automatic logic key_fold(input logic [2:0] k);
    return k <= 3'd4;
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] p);
    logic [95:0] s;
    logic [7:0] r;
    case (k)
      3'd0: s = {"RTP/AVP/UDP", 8'h00};
      3'd1: s = {"RTP/AVP/TCP", 8'h00};
      3'd2: s = {"RAW/RAW/UDP", 8'h00};
      3'd3: s = {"RTP/AVP", 40'h0};
      3'd4: s = {"ssrc=", 56'h0};
      3'd5: s = {"server", "_port="};
      3'd6: s = {"client", "_port="};
      default: s = "interleaved=";
    endcase
    r = s[8'd95 - {p, 3'b000} -: 8];
    return r;
  endfunction

endpackage

// ===== rtl/rthp_segment.sv =====
module rthp_segment (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 is_last_i,
  output logic                 done_o,
  output rthp_pkg::result_t    res_o
);

  logic stop_q, stop_d;
  logic [4:0] pos_q, pos_d;
  logic [7:0] flags_q, flags_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0] phase_q, phase_d;
  logic ended_q, ended_d;
  rthp_pkg::result_t reg_q, reg_d, fin;

  logic [7:0] c, lc;
  logic dig, hexd, is_sep, is_stop, do_close;
  logic [3:0] dval, hval;
  logic [15:0] lo, hi, first;
  logic [16:0] lo_mul, hi_mul;
  logic [4:0] cpos;
  logic [7:0] cflags;
  logic [1:0] cphase;
  logic [31:0] cacc;
  logic cended;

  always_comb begin
    c = text_byte_i;
    lc = rthp_pkg::to_lower(c);
    dig = (c >= 8'h30) && (c <= 8'h39);
    dval = c[3:0];
    hexd = 1'b1;
    if (lc >= 8'h30 && lc <= 8'h39) hval = lc[3:0];
    else if (lc >= 8'h61 && lc <= 8'h66) hval = lc[3:0] + 4'd9;
    else begin
      hval = 4'd0;
      hexd = 1'b0;
    end
    is_sep = (c == rthp_pkg::ChSemi);
    is_stop = (c == rthp_pkg::ChComma) || (c == rthp_pkg::ChCr) ||
              (c == rthp_pkg::ChLf) || (c == rthp_pkg::ChNul);

    stop_d = stop_q;
    pos_d = pos_q;
    flags_d = flags_q;
    acc_d = acc_q;
    phase_d = phase_q;
    ended_d = ended_q;
    reg_d = reg_q;
    do_close = 1'b0;

    lo = acc_q[15:0];
    hi = acc_q[31:16];
    lo_mul = 17'((lo * 16'd10) + 16'(dval));
    hi_mul = 17'((hi * 16'd10) + 16'(dval));

    if (step_i && !stop_q) begin
      if (is_sep || is_stop) begin
        do_close = 1'b1;
        stop_d = is_stop;
      end else begin
        for (int k = 0; k < rthp_pkg::NumKeys; k++) begin
          if (flags_q[k] && ({1'b0, pos_q} < {2'b00, rthp_pkg::key_len(3'(k))})) begin
            if (rthp_pkg::key_fold(3'(k))) begin
              if (lc != rthp_pkg::to_lower(rthp_pkg::key_char(3'(k), pos_q[3:0])))
                flags_d[k] = 1'b0;
            end else if (c != rthp_pkg::key_char(3'(k), pos_q[3:0])) begin
              flags_d[k] = 1'b0;
            end
          end
        end
        if (flags_d[rthp_pkg::KeySsrc] && pos_q >= 5'd5 && pos_q <= 5'd12) begin
          if (hexd) acc_d = {acc_q[27:0], hval};
          else ended_d = 1'b1;
        end
        if ((flags_d[rthp_pkg::KeySrv] || flags_d[rthp_pkg::KeyCli] ||
             flags_d[rthp_pkg::KeyIlv]) && pos_q >= 5'd12 && !ended_q) begin
          case (phase_q)
            2'd0: if (dig) begin
              acc_d[15:0] = 16'(dval);
              phase_d = 2'd1;
            end else ended_d = 1'b1;
            2'd1: if (dig) acc_d[15:0] = lo_mul[15:0];
              else if (c == rthp_pkg::ChDash) phase_d = 2'd2;
              else ended_d = 1'b1;
            2'd2: if (dig) begin
              acc_d[31:16] = 16'(dval);
              phase_d = 2'd3;
            end else ended_d = 1'b1;
            default: if (dig) acc_d[31:16] = hi_mul[15:0];
              else ended_d = 1'b1;
          endcase
        end
        if (pos_q < rthp_pkg::PosMax) pos_d = pos_q + 5'd1;
      end
    end
    if (step_i && is_last_i && !stop_d) do_close = 1'b1;

    cpos = do_close && !(step_i && !stop_q && (is_sep || is_stop)) ? pos_d : pos_q;
    cflags = do_close && !(step_i && !stop_q && (is_sep || is_stop)) ? flags_d : flags_q;
    cacc = do_close && !(step_i && !stop_q && (is_sep || is_stop)) ? acc_d : acc_q;
    cphase = do_close && !(step_i && !stop_q && (is_sep || is_stop)) ? phase_d : phase_q;
    cended = do_close && !(step_i && !stop_q && (is_sep || is_stop)) ? ended_d : ended_q;
    first = 16'd0;

    if (do_close) begin
      if (cflags[rthp_pkg::KeyUdp] && cpos == 5'd11) reg_d.kind = rthp_pkg::KindRtpUdp;
      else if (cflags[rthp_pkg::KeyTcp] && cpos == 5'd11) reg_d.kind = rthp_pkg::KindRtpTcp;
      else if (cflags[rthp_pkg::KeyRaw] && cpos == 5'd11) reg_d.kind = rthp_pkg::KindRawUdp;
      else if (cflags[rthp_pkg::KeyAvp] && cpos == 5'd7) reg_d.kind = rthp_pkg::KindRtpUdp;
      if (cflags[rthp_pkg::KeySsrc] && cpos == 5'd13 && !cended) reg_d.ssrc = cacc;
      if (cpos >= 5'd12 && cphase != 2'd0) begin
        first = cacc[15:0];
        if (!cflags[rthp_pkg::KeyIlv] || cflags[rthp_pkg::KeySrv] ||
            cflags[rthp_pkg::KeyCli]) first[0] = 1'b0;
        if (cphase != 2'd3) begin
          lo = first;
          hi = first + 16'd1;
        end else begin
          lo = cacc[15:0];
          hi = cacc[31:16];
        end
        if (cflags[rthp_pkg::KeySrv]) begin
          reg_d.srv_rtp = lo;
          reg_d.srv_rtcp = hi;
        end else if (cflags[rthp_pkg::KeyCli]) begin
          reg_d.cli_rtp = lo;
          reg_d.cli_rtcp = hi;
        end else if (cflags[rthp_pkg::KeyIlv]) begin
          reg_d.data_ch = lo;
          reg_d.ctrl_ch = hi;
        end
      end
      pos_d = 5'd0;
      flags_d = '1;
      acc_d = 32'd0;
      phase_d = 2'd0;
      ended_d = 1'b0;
    end
    fin = reg_d;
    if (step_i && is_last_i) begin
      stop_d = 1'b0;
      reg_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
      pos_q <= 5'd0;
      flags_q <= '1;
      acc_q <= 32'd0;
      phase_q <= 2'd0;
      ended_q <= 1'b0;
      reg_q <= '0;
    end else begin
      stop_q <= stop_d;
      pos_q <= pos_d;
      flags_q <= flags_d;
      acc_q <= acc_d;
      phase_q <= phase_d;
      ended_q <= ended_d;
      reg_q <= reg_d;
    end
  end

  assign done_o = step_i && is_last_i;
  assign res_o = fin;

endmodule

// ===== rtl/rtsp_transport_header_parser.sv =====
// Channel  Handshake          Payload
// in       in_valid/in_stall  text_byte, is_last
// out      out_valid/out_stall  transport fields, sync_source
// One word is accepted per cycle while in_stall_o is low; the segment state updates in the same cycle.
// The result appears in the cycle after the last word is accepted and sits in an output register.
// A new word is taken while the output register is empty or being drained.
// Reset clears all parse state and drops out_valid_o.
module rtsp_transport_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  transport_kind_o,
  output logic [15:0] client_rtp_port_o,
  output logic [15:0] client_rtcp_port_o,
  output logic [15:0] server_rtp_port_o,
  output logic [15:0] server_rtcp_port_o,
  output logic [15:0] data_channel_o,
  output logic [15:0] control_channel_o,
  output logic [31:0] sync_source_o
);

  logic step, done;
  rthp_pkg::result_t res, out_q;
  logic out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign step = in_valid_i && !in_stall_o;

  rthp_segment u_seg (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(step), .text_byte_i(text_byte_i),
    .is_last_i(is_last_i), .done_o(done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign transport_kind_o = out_q.kind;
  assign client_rtp_port_o = out_q.cli_rtp;
  assign client_rtcp_port_o = out_q.cli_rtcp;
  assign server_rtp_port_o = out_q.srv_rtp;
  assign server_rtcp_port_o = out_q.srv_rtcp;
  assign data_channel_o = out_q.data_ch;
  assign control_channel_o = out_q.ctrl_ch;
  assign sync_source_o = out_q.ssrc;

endmodule

// ===== rtl/rthp_checker.sv =====
module rthp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  transport_kind_o
);

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> transport_kind_o <= rthp_pkg::KindRawUdp) else $error("bad kind");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && is_last_i) |=> out_valid_o) else $error("no result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result lost");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("needless stall");

endmodule

bind rtsp_transport_header_parser rthp_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .is_last_i(is_last_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .transport_kind_o(transport_kind_o)
);

// ===== tb/tb_top.sv =====
module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  transport_kind_o;
  logic [15:0] client_rtp_port_o;
  logic [15:0] client_rtcp_port_o;
  logic [15:0] server_rtp_port_o;
  logic [15:0] server_rtcp_port_o;
  logic [15:0] data_channel_o;
  logic [15:0] control_channel_o;
  logic [31:0] sync_source_o;

  rtsp_transport_header_parser u_dut (.*);

  typedef struct {
    string txt;
    logic  has_exp;
    int    nul_pos;
    rthp_pkg::result_t exp;
  } hdr_row_t;

  // Parser state of the predictor.
  logic        ps_stopped;
  logic [4:0]  ps_pos;
  logic [9:0]  ps_flags;
  logic [31:0] ps_acc;
  logic [1:0]  ps_phase;
  logic        ps_ended;
  logic [1:0]  ps_kind;
  logic [15:0] ps_regs [6];
  logic [31:0] ps_ssrc;

  rthp_pkg::result_t hdr_results_q[$];
  int  n_errors = 0;
  int  n_words = 0;
  int  n_headers = 0;
  int  n_checked = 0;
  bit  quiet_phase = 0;
  bit  hold_long = 0;

  function automatic logic [7:0] fold_ch(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic string key_str(int k);
    string port_sfx;
    port_sfx = "_port=";
    case (k)
      rthp_pkg::KeyUdp: return "RTP/AVP/UDP";
      rthp_pkg::KeyTcp: return "RTP/AVP/TCP";
      rthp_pkg::KeyRaw: return "RAW/RAW/UDP";
      rthp_pkg::KeyAvp: return "RTP/AVP";
      rthp_pkg::KeySsrc: return "ssrc=";
      rthp_pkg::KeySrv: return {"server", port_sfx};
      rthp_pkg::KeyCli: return {"client", port_sfx};
      default: return "interleaved=";
    endcase
  endfunction

  task automatic clear_segment();
    ps_pos = 5'd0;
    ps_flags = 10'h3ff;
    ps_acc = 32'd0;
    ps_phase = 2'd0;
    ps_ended = 1'b0;
  endtask

  task automatic clear_header();
    ps_stopped = 1'b0;
    ps_kind = rthp_pkg::KindRtpUdp;
    ps_ssrc = 32'd0;
    foreach (ps_regs[i]) ps_regs[i] = 16'd0;
    clear_segment();
  endtask

  task automatic feed_char(logic [7:0] c);
    string s;
    logic [7:0] want;
    logic [15:0] lo, hi;
    logic [3:0] d;
    logic dig;
    logic [7:0] l;
    for (int k = 0; k < rthp_pkg::NumKeys; k++) begin
      s = key_str(k);
      if (ps_flags[k] && ps_pos < s.len()) begin
        want = s[ps_pos];
        if (k <= rthp_pkg::KeySsrc ? fold_ch(c) != fold_ch(want) : c != want)
          ps_flags[k] = 1'b0;
      end
    end
    if (ps_flags[rthp_pkg::KeySsrc] && ps_pos >= 5 && ps_pos <= 12) begin
      l = fold_ch(c);
      if (l >= "0" && l <= "9") ps_acc = {ps_acc[27:0], 4'(l - "0")};
      else if (l >= "a" && l <= "f") ps_acc = {ps_acc[27:0], 4'(l - "a" + 10)};
      else ps_ended = 1'b1;
    end
    if ((ps_flags[rthp_pkg::KeySrv] || ps_flags[rthp_pkg::KeyCli] ||
         ps_flags[rthp_pkg::KeyIlv]) && ps_pos >= 12 && !ps_ended) begin
      dig = c >= "0" && c <= "9";
      d = 4'(c - "0");
      lo = ps_acc[15:0];
      hi = ps_acc[31:16];
      case (ps_phase)
        2'd0: if (dig) begin lo = 16'(d); ps_phase = 2'd1; end else ps_ended = 1'b1;
        2'd1: begin
          if (dig) lo = 16'(lo * 16'd10 + 16'(d));
          else if (c == rthp_pkg::ChDash) ps_phase = 2'd2;
          else ps_ended = 1'b1;
        end
        2'd2: if (dig) begin hi = 16'(d); ps_phase = 2'd3; end else ps_ended = 1'b1;
        default: if (dig) hi = 16'(hi * 16'd10 + 16'(d)); else ps_ended = 1'b1;
      endcase
      ps_acc = {hi, lo};
    end
    if (ps_pos < rthp_pkg::PosMax) ps_pos = ps_pos + 5'd1;
  endtask

  task automatic close_segment();
    int base;
    logic is_port;
    logic [15:0] first;
    base = -1;
    is_port = 1'b1;
    if (ps_flags[rthp_pkg::KeyUdp] && ps_pos == 11) ps_kind = rthp_pkg::KindRtpUdp;
    else if (ps_flags[rthp_pkg::KeyTcp] && ps_pos == 11) ps_kind = rthp_pkg::KindRtpTcp;
    else if (ps_flags[rthp_pkg::KeyRaw] && ps_pos == 11) ps_kind = rthp_pkg::KindRawUdp;
    else if (ps_flags[rthp_pkg::KeyAvp] && ps_pos == 7) ps_kind = rthp_pkg::KindRtpUdp;
    if (ps_flags[rthp_pkg::KeySsrc] && ps_pos == 13 && !ps_ended) ps_ssrc = ps_acc;
    if (ps_flags[rthp_pkg::KeySrv]) base = 2;
    else if (ps_flags[rthp_pkg::KeyCli]) base = 0;
    else if (ps_flags[rthp_pkg::KeyIlv]) begin base = 4; is_port = 1'b0; end
    if (base >= 0 && ps_pos >= 12) begin
      if (ps_phase == 2'd3) begin
        ps_regs[base] = ps_acc[15:0];
        ps_regs[base + 1] = ps_acc[31:16];
      end else if (ps_phase != 2'd0) begin
        first = is_port ? {ps_acc[15:1], 1'b0} : ps_acc[15:0];
        ps_regs[base] = first;
        ps_regs[base + 1] = first + 16'd1;
      end
    end
    clear_segment();
  endtask

  task automatic predict_word(logic [7:0] c, logic last);
    rthp_pkg::result_t r;
    if (!ps_stopped) begin
      if (c == rthp_pkg::ChSemi) close_segment();
      else if (c == rthp_pkg::ChComma || c == rthp_pkg::ChCr || c == rthp_pkg::ChLf ||
               c == rthp_pkg::ChNul) begin
        close_segment();
        ps_stopped = 1'b1;
      end else feed_char(c);
    end
    if (last) begin
      if (!ps_stopped) close_segment();
      r.kind = ps_kind;
      r.cli_rtp = ps_regs[0];
      r.cli_rtcp = ps_regs[1];
      r.srv_rtp = ps_regs[2];
      r.srv_rtcp = ps_regs[3];
      r.data_ch = ps_regs[4];
      r.ctrl_ch = ps_regs[5];
      r.ssrc = ps_ssrc;
      hdr_results_q.push_back(r);
      clear_header();
    end
  endtask

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("rtsp_transport_header_parser verification failed");
    $finish;
  end

  task automatic send_word(logic [7:0] c, logic last);
    int gap;
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    text_byte_i <= c;
    is_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(c, last);
    n_words++;
    if (last) n_headers++;
  endtask

  // The byte at nul_pos goes out as NUL, which a string cannot hold.
  task automatic send_header(string txt, int nul_pos);
    logic [7:0] c;
    for (int i = 0; i < txt.len(); i++) begin
      c = (i == nul_pos) ? rthp_pkg::ChNul : txt[i];
      send_word(c, i == txt.len() - 1);
    end
  endtask

  function automatic string rand_num(int maxd);
    string s;
    int n;
    s = "";
    n = $urandom_range(1, maxd);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_segment();
    string s;
    byte unsigned hx;
    int n;
    case ($urandom_range(0, 11))
      0: s = key_str($urandom_range(0, 3));
      1: begin
        s = key_str($urandom_range(0, 3));
        for (int i = 0; i < s.len(); i++)
          if ($urandom_range(0, 1) && s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 8'd32;
      end
      2, 3: begin
        s = {key_str($urandom_range(5, 7)), rand_num(6)};
        if ($urandom_range(0, 1)) s = {s, "-", rand_num(6)};
      end
      4: s = {key_str($urandom_range(5, 7)), rand_num(2), "-"};
      5, 6: begin
        s = $urandom_range(0, 1) ? "ssrc=" : "SSRC=";
        n = $urandom_range(0, 4) == 0 ? $urandom_range(0, 10) : 8;
        for (int i = 0; i < n; i++) begin
          hx = $urandom_range(0, 21);
          s = {s, string'(8'(hx < 10 ? "0" + hx : (hx < 16 ? "a" + hx - 10 : "A" + hx - 16)))};
        end
      end
      7: s = {key_str($urandom_range(5, 7)), $urandom_range(0, 1) ? "+" : " ", rand_num(3)};
      8: begin
        s = key_str($urandom_range(0, 7));
        s = s.substr(0, $urandom_range(0, s.len() - 1));
      end
      default: begin
        s = "";
        n = $urandom_range(0, 14);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
      end
    endcase
    return s;
  endfunction

  function automatic string rand_header(output int nul_pos);
    string s;
    int n;
    byte unsigned t;
    s = "";
    nul_pos = -1;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if (i != 0) s = {s, ";"};
      s = {s, rand_segment()};
    end
    if ($urandom_range(0, 3) == 0) begin
      t = $urandom_range(0, 3);
      if (t == 3) begin
        nul_pos = s.len();
        s = {s, "x"};
      end else begin
        s = {s, string'(t == 0 ? rthp_pkg::ChComma : t == 1 ? rthp_pkg::ChCr : rthp_pkg::ChLf)};
      end
      s = {s, rand_segment()};
    end
    if (s.len() == 0) s = "x";
    return s;
  endfunction

  task automatic send_rand_header();
    string h;
    int np;
    h = rand_header(np);
    send_header(h, np);
  endtask

  hdr_row_t dir_rows[$];

  function automatic rthp_pkg::result_t zero_res();
    rthp_pkg::result_t r;
    r = '0;
    return r;
  endfunction

  function automatic hdr_row_t row(string t, logic h, rthp_pkg::result_t e, int np);
    hdr_row_t r;
    r.txt = t;
    r.has_exp = h;
    r.exp = e;
    r.nul_pos = np;
    return r;
  endfunction

  initial begin
    rthp_pkg::result_t e;
    string nul_hdr;
    string cli_key;
    string srv_key;
    rst_ni = 0;
    in_valid_i = 0;
    text_byte_i = 0;
    is_last_i = 0;
    out_stall_i = 0;
    clear_header();
    cli_key = key_str(rthp_pkg::KeyCli);
    srv_key = key_str(rthp_pkg::KeySrv);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    e = zero_res();
    dir_rows.push_back(row("x", 1, e, -1));
    e.kind = rthp_pkg::KindRtpTcp;
    dir_rows.push_back(row("rtp/avp/tcp", 1, e, -1));
    e.kind = rthp_pkg::KindRawUdp;
    dir_rows.push_back(row("RAW/RAW/UDP", 1, e, -1));
    dir_rows.push_back(row("RTP/AVP/TCP;RTP/AVP", 0, e, -1));
    dir_rows.push_back(row("RTP/AVP/UDP;unicast", 0, e, -1));
    e = zero_res();
    e.cli_rtp = 16'd65534;
    e.cli_rtcp = 16'd65535;
    dir_rows.push_back(row({cli_key, "65535"}, 1, e, -1));
    e = zero_res();
    e.srv_rtp = 16'd0;
    e.srv_rtcp = 16'd65535;
    dir_rows.push_back(row({srv_key, "65536-65535"}, 1, e, -1));
    e = zero_res();
    e.data_ch = 16'd65535;
    e.ctrl_ch = 16'd0;
    dir_rows.push_back(row("interleaved=65535", 1, e, -1));
    dir_rows.push_back(row({"interleaved=2-3;", cli_key, "4001"}, 0, e, -1));
    dir_rows.push_back(row({cli_key, "-5;", srv_key, " 8"}, 0, e, -1));
    dir_rows.push_back(row({"C", cli_key.substr(1, cli_key.len() - 1), "12;", cli_key}, 0, e,
                           -1));
    dir_rows.push_back(row({cli_key, "12-;", srv_key, "7x"}, 0, e, -1));
    e = zero_res();
    e.ssrc = 32'hffffffff;
    dir_rows.push_back(row("SSRC=FFFFffff", 1, e, -1));
    dir_rows.push_back(row("ssrc=00000000", 0, e, -1));
    dir_rows.push_back(row("ssrc=1234567;ssrc=123456789;ssrc=1234567g", 0, e, -1));
    dir_rows.push_back(row("RTP/AVP/TCP,ssrc=12345678", 0, e, -1));
    dir_rows.push_back(row({"RTP/AVP/TCP\r", cli_key, "8"}, 0, e, -1));
    dir_rows.push_back(row({"RTP/AVP/TCP\n", cli_key, "8"}, 0, e, -1));
    nul_hdr = {"RTP/AVP/TCP;", cli_key, "8"};
    nul_hdr[11] = 8'hff;
    dir_rows.push_back(row(nul_hdr, 0, e, -1));
    nul_hdr = {"ssrc=deadbeef;x", cli_key, "4;"};
    dir_rows.push_back(row(nul_hdr, 0, e, 13));
    dir_rows.push_back(row({cli_key, "0123456789012345678901234567"}, 0, e, -1));

    foreach (dir_rows[i]) begin
      send_header(dir_rows[i].txt, dir_rows[i].nul_pos);
      if (dir_rows[i].has_exp && hdr_results_q[$] != dir_rows[i].exp) begin
        n_errors++;
        $display("%0t: directed header %0d predicted %p, table says %p", $time, i,
                 hdr_results_q[$], dir_rows[i].exp);
      end
    end

    while (n_words < 1750) begin
      if (n_headers == 60) begin
        hold_long = 1;
        send_rand_header();
        send_rand_header();
      end
      if (n_words > 1450) quiet_phase = 1;
      send_rand_header();
    end
    in_valid_i <= 0;
    while (hdr_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Parsed %0d headers from %0d words; %0d results checked.", n_headers, n_words,
             n_checked);
    if (n_errors == 0) $display("rtsp_transport_header_parser verification clean");
    else $display("rtsp_transport_header_parser verification failed");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        hold_long = 0;
        out_stall_i <= 1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 14);
        out_stall_i <= 1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    rthp_pkg::result_t got;
    rthp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {transport_kind_o, client_rtp_port_o, client_rtcp_port_o, server_rtp_port_o,
             server_rtcp_port_o, data_channel_o, control_channel_o, sync_source_o};
      if (hdr_results_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = hdr_results_q.pop_front();
        n_checked++;
        if (got.kind != want.kind || got.cli_rtp != want.cli_rtp ||
            got.cli_rtcp != want.cli_rtcp || got.srv_rtp != want.srv_rtp ||
            got.srv_rtcp != want.srv_rtcp || got.data_ch != want.data_ch ||
            got.ctrl_ch != want.ctrl_ch || got.ssrc != want.ssrc) begin
          n_errors++;
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/rthp_pkg.sv
rtl/rthp_segment.sv
rtl/rtsp_transport_header_parser.sv
rtl/rthp_checker.sv
tb/tb_top.sv
